// ===== sv/distance_glow_band_blend_defines.svh =====
// Assertion macros for the glow blend block.
// Both sample on clk and are disabled while rst_n is low.
`ifndef DISTANCE_GLOW_BAND_BLEND_DEFINES_SVH
`define DISTANCE_GLOW_BAND_BLEND_DEFINES_SVH

// Same-cycle implication
`define DGBB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define DGBB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/dgbb_pkg.sv =====
`timescale 1ns / 1ps

package dgbb_pkg;

  // Field widths
  localparam int COLOR_W   = 24;
  localparam int DIST_W    = 16;
  localparam int COL_W     = 11;
  localparam int CFG_IDX_W = 3;
  localparam int Q_W       = 16;   // weight, Q0.16

  // Register reset values
  localparam logic [COLOR_W-1:0] LINE_COLOR_RST = 24'h000000;
  localparam logic [COLOR_W-1:0] BG_COLOR_RST   = 24'hFFFFFF;
  localparam logic [COL_W-1:0]   BAND_WIDTH_RST = 11'd100;
  localparam logic [DIST_W-1:0]  DIST_THR_RST   = 16'd320;
  localparam logic [COL_W-1:0]   BAND_LEFT_RST  = 11'd0;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_COLOR = 3'd0,
    REG_BG_COLOR   = 3'd1,
    REG_BAND_WIDTH = 3'd2,
    REG_DIST_THR   = 3'd3,
    REG_BAND_LEFT  = 3'd4
  } cfg_idx_t;

  // Pixel: index 0 blue, 1 green, 2 red (same packing as the colour registers)
  typedef logic [2:0][7:0] pix_t;

  // What the last stage does with a pixel
  typedef enum logic [1:0] {
    MODE_PASS  = 2'd0,
    MODE_LINE  = 2'd1,
    MODE_BLEND = 2'd2
  } mode_t;

  typedef struct packed {
    mode_t mode;
    pix_t  pix;
  } meta_t;

endpackage

// ===== sv/dgbb_div_stage.sv =====
`timescale 1ns / 1ps

// One restoring division step as a pipeline stage: one quotient bit per stage.
module dgbb_div_stage #(
  parameter int DW = 24,
  parameter int QW = 16
) (
  input  logic                clk,
  input  logic                ld,
  input  logic [DW-1:0]       dsr,
  input  logic [DW-1:0]       rem_i,
  input  logic [QW-1:0]       quo_i,
  input  dgbb_pkg::meta_t     meta_i,
  output logic [DW-1:0]       rem_o,
  output logic [QW-1:0]       quo_o,
  output dgbb_pkg::meta_t     meta_o
);
  import dgbb_pkg::*;

  logic [DW:0]   rem2;
  logic [DW:0]   sub;
  logic          ge;
  logic [DW-1:0] rem_nxt;
  logic [QW-1:0] quo_nxt;
  logic [DW-1:0] rem_r;
  logic [QW-1:0] quo_r;
  meta_t         meta_r;

  // shift, trial subtract, keep if it fits
  always_comb begin
    rem2    = {rem_i, 1'b0};
    sub     = rem2 - {1'b0, dsr};
    ge      = (rem2 >= {1'b0, dsr});
    rem_nxt = ge ? sub[DW-1:0] : rem2[DW-1:0];
    quo_nxt = {quo_i[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      meta_r <= meta_i;
    end
  end

  assign rem_o  = rem_r;
  assign quo_o  = quo_r;
  assign meta_o = meta_r;

endmodule

// ===== sv/distance_glow_band_blend.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// in_       request    in_valid/in_ready  pixel_blue/green/red, line_distance, column
// out_      result     out_valid/out_ready out_blue/green/red
// cfg_      write      cfg_we             cfg_index, cfg_wdata
//
// One pixel per clock sustained while the output is not stalled.
// The pipeline is the 16-stage weight divider, one quotient bit per stage,
// plus input, classify, numerator, product and output stages (21 in all).
// Synchronous reset clears the stage valid bits and loads the register defaults.
// Each stage has its own ready, so a stalled output only holds full stages
// and requests keep coming in while empty stages remain.
module distance_glow_band_blend #(
  parameter int RAMP_COLUMNS = 50
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_pixel_blue,
  input  logic [7:0]                     in_pixel_green,
  input  logic [7:0]                     in_pixel_red,
  input  logic [dgbb_pkg::DIST_W-1:0]    in_line_distance,
  input  logic [dgbb_pkg::COL_W-1:0]     in_column,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_blue,
  output logic [7:0]                     out_green,
  output logic [7:0]                     out_red,
  // configuration
  input  logic                           cfg_we,
  input  logic [dgbb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dgbb_pkg::COLOR_W-1:0]   cfg_wdata
);
  import dgbb_pkg::*;

`include "distance_glow_band_blend_defines.svh"

  localparam int NW    = $clog2(RAMP_COLUMNS + 1);
  localparam int DW    = DIST_W + NW;
  localparam int SW    = COL_W + 3;
  localparam int PW    = Q_W + 9;
  localparam int S_DIV = 3;
  localparam int S_PRD = S_DIV + Q_W;
  localparam int S_OUT = S_PRD + 1;
  localparam int NST   = S_OUT + 1;

  localparam logic signed [SW-1:0] RAMP_S = SW'(RAMP_COLUMNS);
  localparam logic [DW-1:0]        RAMP_D = DW'(RAMP_COLUMNS);

  // ---------------- configuration registers ----------------
  logic [COLOR_W-1:0] line_color_r;
  logic [COLOR_W-1:0] bg_color_r;
  logic [COL_W-1:0]   band_width_r;
  logic [DIST_W-1:0]  dist_thr_r;
  logic [COL_W-1:0]   band_left_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_color_r <= LINE_COLOR_RST;
      bg_color_r   <= BG_COLOR_RST;
      band_width_r <= BAND_WIDTH_RST;
      dist_thr_r   <= DIST_THR_RST;
      band_left_r  <= BAND_LEFT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_LINE_COLOR: line_color_r <= cfg_wdata;
        REG_BG_COLOR:   bg_color_r   <= cfg_wdata;
        REG_BAND_WIDTH: band_width_r <= cfg_wdata[COL_W-1:0];
        REG_DIST_THR:   dist_thr_r   <= cfg_wdata[DIST_W-1:0];
        REG_BAND_LEFT:  band_left_r  <= cfg_wdata[COL_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- stage valids and ready chain ----------------
  logic [NST-1:0] v_r;
  logic [NST-1:0] v_in;
  logic [NST:0]   rdy;

  always_comb begin
    rdy[NST] = out_ready;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign v_in = {v_r[NST-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (rdy[k]) v_r[k] <= v_in[k];
      end
    end
  end

  assign in_ready = rdy[0];

  // ---------------- stage 0: capture request ----------------
  pix_t              s0_pix_r;
  logic [DIST_W-1:0] s0_dist_r;
  logic [COL_W-1:0]  s0_col_r;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s0_pix_r  <= {in_pixel_red, in_pixel_green, in_pixel_blue};
      s0_dist_r <= in_line_distance;
      s0_col_r  <= in_column;
    end
  end

  // ---------------- stage 1: ramp numerator and classification ----------------
  logic signed [SW-1:0] left_s, right_s, lo_s, hi_s, col_s, ramp_s;
  logic [NW-1:0]        n_nxt;
  mode_t                mode_nxt;
  logic [DIST_W-1:0]    diff_nxt;

  always_comb begin
    left_s  = $signed({{(SW-COL_W){1'b0}}, band_left_r});
    right_s = left_s + $signed({{(SW-COL_W){1'b0}}, band_width_r});
    col_s   = $signed({{(SW-COL_W){1'b0}}, s0_col_r});
    lo_s    = left_s - RAMP_S;
    hi_s    = right_s + RAMP_S;
    priority if (col_s >= left_s && col_s <= right_s) begin
      ramp_s = RAMP_S;
    end else if (col_s >= lo_s && col_s < left_s) begin
      ramp_s = col_s - lo_s;
    end else if (col_s > right_s && col_s <= hi_s) begin
      ramp_s = hi_s - col_s;
    end else begin
      ramp_s = '0;
    end
    n_nxt = ramp_s[NW-1:0];

    // zero distance wins over the ramp; far or off-ramp passes through
    priority if (s0_dist_r == '0) begin
      mode_nxt = MODE_LINE;
    end else if (s0_dist_r >= dist_thr_r || n_nxt == '0) begin
      mode_nxt = MODE_PASS;
    end else begin
      mode_nxt = MODE_BLEND;
    end
    diff_nxt = dist_thr_r - s0_dist_r;
  end

  meta_t             s1_meta_r;
  logic [DIST_W-1:0] s1_diff_r;
  logic [NW-1:0]     s1_n_r;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_meta_r <= '{mode: mode_nxt, pix: s0_pix_r};
      s1_diff_r <= diff_nxt;
      s1_n_r    <= n_nxt;
    end
  end

  // ---------------- stage 2: numerator (T-d)*n ----------------
  meta_t         s2_meta_r;
  logic [DW-1:0] s2_num_r;
  logic [DW-1:0] num_nxt;
  logic [DW-1:0] dsr;

  assign num_nxt = {{NW{1'b0}}, s1_diff_r} * {{DIST_W{1'b0}}, s1_n_r};
  // divisor RAMP_COLUMNS*T; the user must keep it fixed while pixels are in flight, the block does not enforce it
  assign dsr     = {{NW{1'b0}}, dist_thr_r} * RAMP_D;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_meta_r <= s1_meta_r;
      s2_num_r  <= num_nxt;
    end
  end

  // ---------------- stages 3..18: w = num*2^16 / dsr ----------------
  logic [DW-1:0]  rem_a  [0:Q_W];
  logic [Q_W-1:0] quo_a  [0:Q_W];
  meta_t          meta_a [0:Q_W];

  assign rem_a[0]  = s2_num_r;
  assign quo_a[0]  = '0;
  assign meta_a[0] = s2_meta_r;

  for (genvar k = 0; k < Q_W; k++) begin : g_div
    dgbb_div_stage #(
      .DW (DW),
      .QW (Q_W)
    ) u_div (
      .clk    (clk),
      .ld     (rdy[S_DIV+k]),
      .dsr    (dsr),
      .rem_i  (rem_a[k]),
      .quo_i  (quo_a[k]),
      .meta_i (meta_a[k]),
      .rem_o  (rem_a[k+1]),
      .quo_o  (quo_a[k+1]),
      .meta_o (meta_a[k+1])
    );
  end

  // ---------------- stage 19: blend products ----------------
  logic [Q_W-1:0] w;
  logic [Q_W:0]   inv_w;
  pix_t           bg_pix, ln_pix;
  logic [PW-1:0]  bgp_nxt [3];
  logic [PW-1:0]  lnp_nxt [3];

  assign w      = quo_a[Q_W];
  assign inv_w  = {1'b1, {Q_W{1'b0}}} - {1'b0, w};
  assign bg_pix = bg_color_r;
  assign ln_pix = line_color_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      bgp_nxt[c] = PW'(bg_pix[c]) * PW'(inv_w);
      lnp_nxt[c] = PW'(ln_pix[c]) * PW'(w);
    end
  end

  meta_t         prd_meta_r;
  logic [PW-1:0] bgp_r [3];
  logic [PW-1:0] lnp_r [3];

  always_ff @(posedge clk) begin
    if (rdy[S_PRD]) begin
      prd_meta_r <= meta_a[Q_W];
      for (int c = 0; c < 3; c++) begin
        bgp_r[c] <= bgp_nxt[c];
        lnp_r[c] <= lnp_nxt[c];
      end
    end
  end

  // ---------------- stage 20: sum, select, output register ----------------
  logic [PW-1:0] sum_c [3];
  pix_t          blend_pix;
  pix_t          out_pix_nxt;
  pix_t          out_pix_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_c[c]     = bgp_r[c] + lnp_r[c];
      blend_pix[c] = sum_c[c][Q_W+7:Q_W];
    end
    unique case (prd_meta_r.mode)
      MODE_LINE:  out_pix_nxt = ln_pix;
      MODE_BLEND: out_pix_nxt = blend_pix;
      default:    out_pix_nxt = prd_meta_r.pix;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[S_OUT]) out_pix_r <= out_pix_nxt;
  end

  assign out_valid = v_r[S_OUT];
  assign out_blue  = out_pix_r[0];
  assign out_green = out_pix_r[1];
  assign out_red   = out_pix_r[2];

  // ---------------- assertions ----------------
  `DGBB_ASSERT_NEXT(a_req_enters, in_valid && in_ready, v_r[0], "accepted request not in stage 0")
  `DGBB_ASSERT_NOW(a_block_full, !in_ready, (&v_r) && !out_ready, "input blocked with a bubble")
  `DGBB_ASSERT_NEXT(a_prd_held, v_r[S_OUT] && !out_ready && v_r[S_PRD], v_r[S_PRD], "item lost in stall")

endmodule

// ===== sim/distance_glow_band_blend_tb.sv =====
`timescale 1ns / 1ps

module distance_glow_band_blend_tb;
  import dgbb_pkg::*;

  localparam int RAMP          = 50;
  localparam int RESET_CYCLES  = 10;
  localparam int IDLE_PCT      = 37;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 2000;
  localparam int TAIL_CYCLES   = 50;
  localparam int RAND_PHASES   = 7;
  localparam int PHASE_ITEMS   = 250;
  localparam int PRESSURE_PHASE = 3;
  localparam int STEADY_PHASE  = 4;
  localparam int COL_MAX       = (1 << COL_W) - 1;
  localparam int DIST_MAX      = (1 << DIST_W) - 1;
  localparam int CFG_IDX_MAX   = (1 << CFG_IDX_W) - 1;
  localparam longint unsigned Q_ONE = 64'd1 << Q_W;
  localparam longint unsigned W_MAX = Q_ONE - 1;

  // Register settings used by the directed table
  localparam int SET_RESET        = 0;
  localparam int SET_FAR_CORNER   = 1;
  localparam int SET_NO_THRESHOLD = 2;
  localparam int SET_MASKED_WIDTH = 3;

  // Same packing as the colour registers: red 23:16, blue 7:0
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } glow_px_t;

  typedef struct packed {
    int                setting;
    logic [7:0]        blue;
    logic [7:0]        green;
    logic [7:0]        red;
    logic [DIST_W-1:0] ldist;
    logic [COL_W-1:0]  col;
    bit                has_gold;
    glow_px_t          gold;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [7:0]           in_pixel_blue;
  logic [7:0]           in_pixel_green;
  logic [7:0]           in_pixel_red;
  logic [DIST_W-1:0]    in_line_distance;
  logic [COL_W-1:0]     in_column;
  logic                 out_valid;
  logic                 out_ready;
  logic [7:0]           out_blue;
  logic [7:0]           out_green;
  logic [7:0]           out_red;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COLOR_W-1:0]   cfg_wdata;

  // Shadow copy of the register file
  logic [COLOR_W-1:0] line_color_q = LINE_COLOR_RST;
  logic [COLOR_W-1:0] bg_color_q   = BG_COLOR_RST;
  logic [COL_W-1:0]   band_width_q = BAND_WIDTH_RST;
  logic [DIST_W-1:0]  dist_thr_q   = DIST_THR_RST;
  logic [COL_W-1:0]   band_left_q  = BAND_LEFT_RST;

  glow_px_t  expected_pixels[$];
  stim_row_t stim_rows[$];
  glow_px_t  want_px;
  int        mismatches = 0;
  int        quiet_cycles = 0;
  bit        idle_on = 1'b1;
  bit        hold_off_pending = 1'b0;

  distance_glow_band_blend #(.RAMP_COLUMNS(RAMP)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pixel_blue    (in_pixel_blue),
    .in_pixel_green   (in_pixel_green),
    .in_pixel_red     (in_pixel_red),
    .in_line_distance (in_line_distance),
    .in_column        (in_column),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_blue         (out_blue),
    .out_green        (out_green),
    .out_red          (out_red),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // Clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // One channel: bg toward line by a Q0.16 weight, truncated
  function automatic logic [7:0] blend_chan(input logic [7:0] bg, input logic [7:0] ln,
                                            input longint unsigned wt);
    longint unsigned bgw, lnw, acc;
    bgw = 64'(bg);
    lnw = 64'(ln);
    acc = (bgw * (Q_ONE - wt) + lnw * wt) >> Q_W;
    return acc[7:0];
  endfunction

  // Expected pixel for one request under the shadow registers
  function automatic glow_px_t predict_glow(input logic [7:0] b, input logic [7:0] g,
                                            input logic [7:0] r,
                                            input logic [DIST_W-1:0] ldist,
                                            input logic [COL_W-1:0] col);
    longint          c, left, right, n;
    longint unsigned t, dd, nu, wt;
    glow_px_t        px;
    if (ldist == '0) begin
      px = line_color_q;
      return px;
    end
    c     = longint'(col);
    left  = longint'(band_left_q);
    right = left + longint'(band_width_q);
    // ramp numerator, wide signed so nothing wraps
    if (c >= left && c <= right)
      n = RAMP;
    else if (c >= left - RAMP && c < left)
      n = c - (left - RAMP);
    else if (c > right && c <= right + RAMP)
      n = right + RAMP - c;
    else
      n = 0;
    t  = 64'(dist_thr_q);
    dd = 64'(ldist);
    if (dd >= t || n <= 0) begin
      px.blue  = b;
      px.green = g;
      px.red   = r;
      return px;
    end
    nu = n;
    wt = ((t - dd) * nu * Q_ONE) / (RAMP * t);
    if (wt > W_MAX)
      wt = W_MAX;
    px.blue  = blend_chan(bg_color_q[7:0],   line_color_q[7:0],   wt);
    px.green = blend_chan(bg_color_q[15:8],  line_color_q[15:8],  wt);
    px.red   = blend_chan(bg_color_q[23:16], line_color_q[23:16], wt);
    return px;
  endfunction

  // Register write; only called with the pipeline empty
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_LINE_COLOR: line_color_q = data;
      REG_BG_COLOR:   bg_color_q   = data;
      REG_BAND_WIDTH: band_width_q = data[COL_W-1:0];
      REG_DIST_THR:   dist_thr_q   = data[DIST_W-1:0];
      REG_BAND_LEFT:  band_left_q  = data[COL_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(input logic [COLOR_W-1:0] line_c, input logic [COLOR_W-1:0] bg_c,
                           input logic [COL_W-1:0] width, input logic [DIST_W-1:0] thr,
                           input logic [COL_W-1:0] left);
    cfg_write(REG_LINE_COLOR, line_c);
    cfg_write(REG_BG_COLOR, bg_c);
    cfg_write(REG_BAND_WIDTH, COLOR_W'(width));
    cfg_write(REG_DIST_THR, COLOR_W'(thr));
    cfg_write(REG_BAND_LEFT, COLOR_W'(left));
  endtask

  // Offer one request, hold it until taken, then record what must come out
  task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
                            input logic [DIST_W-1:0] ldist, input logic [COL_W-1:0] col,
                            input bit has_gold, input glow_px_t gold);
    while (idle_on && ($urandom_range(99) < IDLE_PCT)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_pixel_blue    <= b;
    in_pixel_green   <= g;
    in_pixel_red     <= r;
    in_line_distance <= ldist;
    in_column        <= col;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_pixels.push_back(has_gold ? gold : predict_glow(b, g, r, ldist, col));
  endtask

  // Drop valid and wait until every expected pixel has come out
  task automatic finish_burst();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(input int setting, input logic [7:0] b, input logic [7:0] g,
                         input logic [7:0] r, input logic [DIST_W-1:0] ldist,
                         input logic [COL_W-1:0] col, input bit has_gold,
                         input logic [COLOR_W-1:0] gold);
    stim_row_t row;
    row.setting  = setting;
    row.blue     = b;
    row.green    = g;
    row.red      = r;
    row.ldist    = ldist;
    row.col      = col;
    row.has_gold = has_gold;
    row.gold     = gold;
    stim_rows.push_back(row);
  endtask

  task automatic apply_setting(input int setting);
    int i;
    case (setting)
      SET_FAR_CORNER: begin
        write_all(24'hFFFFFF, 24'h123456, 11'd47, 16'd65535, 11'd2000);
        // spare indexes must not alias onto any register
        for (i = int'(REG_BAND_LEFT) + 1; i <= CFG_IDX_MAX; i++)
          cfg_write(CFG_IDX_W'(i), COLOR_W'($urandom));
      end
      SET_NO_THRESHOLD: begin
        cfg_write(REG_DIST_THR, '0);
        cfg_write(REG_BAND_WIDTH, 24'hFFF80A);
        cfg_write(REG_BAND_LEFT, 24'd5);
        cfg_write(REG_LINE_COLOR, 24'h0A0B0C);
        cfg_write(REG_BG_COLOR, 24'h404040);
      end
      SET_MASKED_WIDTH: cfg_write(REG_DIST_THR, 24'd1000);
      default: ;
    endcase
  endtask

  // Per-phase register setting: corners first, then random
  task automatic random_setting(input int phase);
    logic [COL_W-1:0]  left, width;
    logic [DIST_W-1:0] thr;
    case (phase)
      0: write_all(24'h000000, 24'hFFFFFF, 11'd0, 16'd1, 11'd0);
      1: write_all(24'hFFFFFF, 24'h000000, COL_W'(COL_MAX), DIST_W'(DIST_MAX),
                   COL_W'(COL_MAX));
      2: write_all(COLOR_W'($urandom), COLOR_W'($urandom), COL_W'(COL_MAX),
                   DIST_W'(DIST_MAX), 11'd0);
      default: begin
        left  = $urandom_range(1) ? COL_W'($urandom_range(1279))
                                  : COL_W'($urandom_range(COL_MAX));
        width = ($urandom_range(3) == 0) ? COL_W'($urandom_range(COL_MAX))
                                         : COL_W'($urandom_range(200));
        if ($urandom_range(7) == 0)
          thr = '0;
        else if ($urandom_range(1))
          thr = DIST_W'($urandom_range(1000, 1));
        else
          thr = DIST_W'($urandom_range(DIST_MAX, 1));
        write_all(COLOR_W'($urandom), COLOR_W'($urandom), width, thr, left);
      end
    endcase
  endtask

  // Random pixel, mostly near the ramp and inside the threshold
  task automatic send_random();
    logic [DIST_W-1:0] ldist;
    logic [COL_W-1:0]  col;
    int                sel, lo, hi;
    sel = int'($urandom_range(99));
    if (sel < 10)
      ldist = '0;
    else if (sel < 25)
      ldist = DIST_W'($urandom);
    else if (sel < 40 && dist_thr_q != '0)
      ldist = DIST_W'($urandom_range(DIST_MAX, dist_thr_q));
    else if (dist_thr_q > 1)
      ldist = DIST_W'($urandom_range(dist_thr_q - 1, 1));
    else
      ldist = DIST_W'($urandom);
    lo = int'(band_left_q) - RAMP - 2;
    hi = int'(band_left_q) + int'(band_width_q) + RAMP + 2;
    if (lo < 0)
      lo = 0;
    if (hi > COL_MAX)
      hi = COL_MAX;
    if ($urandom_range(9) < 7)
      col = COL_W'($urandom_range(hi, lo));
    else
      col = COL_W'($urandom_range(COL_MAX));
    send_pixel(8'($urandom), 8'($urandom), 8'($urandom), ldist, col, 1'b0, '0);
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_pending) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_pending = 1'b0;
      end
      out_ready <= !(idle_on && ($urandom_range(99) < IDLE_PCT));
    end
  end

  // Result check against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        $error("result with nothing expected: blue %0d green %0d red %0d",
               out_blue, out_green, out_red);
        mismatches++;
      end else begin
        want_px = expected_pixels.pop_front();
        if (out_blue !== want_px.blue) begin
          $error("out_blue: expected %0d, got %0d", want_px.blue, out_blue);
          mismatches++;
        end
        if (out_green !== want_px.green) begin
          $error("out_green: expected %0d, got %0d", want_px.green, out_green);
          mismatches++;
        end
        if (out_red !== want_px.red) begin
          $error("out_red: expected %0d, got %0d", want_px.red, out_red);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Main sequence
  initial begin
    int cur_set;
    int p;
    int k;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_pixel_blue    = '0;
    in_pixel_green   = '0;
    in_pixel_red     = '0;
    in_line_distance = '0;
    in_column        = '0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_wdata        = '0;

    // reset values: line black, background white, band 0..100, threshold 320
    add_row(SET_RESET, 8'hCC, 8'h55, 8'hAA, 16'd0,     11'd500,  1'b1, 24'h000000);
    add_row(SET_RESET, 8'hFF, 8'hFF, 8'hFF, 16'd0,     11'd0,    1'b1, 24'h000000);
    add_row(SET_RESET, 8'h12, 8'h34, 8'h56, 16'd320,   11'd50,   1'b1, 24'h563412);
    add_row(SET_RESET, 8'hFF, 8'hFF, 8'hFF, 16'd65535, 11'd2047, 1'b1, 24'hFFFFFF);
    add_row(SET_RESET, 8'h01, 8'h02, 8'h03, 16'd1,     11'd2047, 1'b1, 24'h030201);
    add_row(SET_RESET, 8'h80, 8'h81, 8'h82, 16'd1,     11'd151,  1'b1, 24'h828180);
    add_row(SET_RESET, 8'h00, 8'h00, 8'h00, 16'd1,     11'd50,   1'b0, '0);
    add_row(SET_RESET, 8'h00, 8'hFF, 8'h00, 16'd319,   11'd100,  1'b0, '0);
    add_row(SET_RESET, 8'h5A, 8'hA5, 8'h0F, 16'd160,   11'd101,  1'b0, '0);
    add_row(SET_RESET, 8'hFF, 8'h00, 8'hFF, 16'd1,     11'd150,  1'b0, '0);
    add_row(SET_RESET, 8'h33, 8'h66, 8'h99, 16'd319,   11'd150,  1'b0, '0);
    add_row(SET_RESET, 8'h10, 8'h20, 8'h30, 16'd100,   11'd0,    1'b0, '0);
    // band at the top of the column range, threshold at its maximum
    add_row(SET_FAR_CORNER, 8'h00, 8'h00, 8'h00, 16'd1,     11'd1950, 1'b1, 24'h000000);
    // weight truncates to zero: background exactly
    add_row(SET_FAR_CORNER, 8'hAB, 8'hCD, 8'hEF, 16'd65534, 11'd1951, 1'b1, 24'h123456);
    add_row(SET_FAR_CORNER, 8'h00, 8'h00, 8'h00, 16'd1,     11'd2047, 1'b0, '0);
    add_row(SET_FAR_CORNER, 8'h11, 8'h22, 8'h33, 16'd65535, 11'd2000, 1'b1, 24'h332211);
    add_row(SET_FAR_CORNER, 8'h77, 8'h88, 8'h99, 16'd30000, 11'd1975, 1'b0, '0);
    add_row(SET_FAR_CORNER, 8'h01, 8'h01, 8'h01, 16'd0,     11'd1000, 1'b1, 24'hFFFFFF);
    // threshold zero: anything but distance zero passes
    add_row(SET_NO_THRESHOLD, 8'h01, 8'h02, 8'h03, 16'd1,     11'd10, 1'b1, 24'h030201);
    add_row(SET_NO_THRESHOLD, 8'hF0, 8'h0F, 8'hAA, 16'd65535, 11'd10, 1'b1, 24'hAA0FF0);
    add_row(SET_NO_THRESHOLD, 8'hF0, 8'h0F, 8'hAA, 16'd0,     11'd10, 1'b1, 24'h0A0B0C);
    // width written with bits above 11 set
    add_row(SET_MASKED_WIDTH, 8'hFF, 8'hFF, 8'hFF, 16'd500, 11'd15, 1'b0, '0);
    add_row(SET_MASKED_WIDTH, 8'hFF, 8'hFF, 8'hFF, 16'd500, 11'd16, 1'b0, '0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    cur_set = SET_RESET;
    foreach (stim_rows[i]) begin
      if (stim_rows[i].setting != cur_set) begin
        finish_burst();
        apply_setting(stim_rows[i].setting);
        cur_set = stim_rows[i].setting;
      end
      send_pixel(stim_rows[i].blue, stim_rows[i].green, stim_rows[i].red,
                 stim_rows[i].ldist, stim_rows[i].col, stim_rows[i].has_gold,
                 stim_rows[i].gold);
    end

    // random phases, each under a fresh register setting
    for (p = 0; p < RAND_PHASES; p++) begin
      finish_burst();
      random_setting(p);
      idle_on = (p != STEADY_PHASE);
      if (p == PRESSURE_PHASE)
        hold_off_pending = 1'b1;
      for (k = 0; k < PHASE_ITEMS; k++)
        send_random();
    end
    idle_on = 1'b1;

    finish_burst();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
